>>> hdl/tvsn_pkg.sv
// ----------------------------------------------------------------------------
// tvsn_pkg
// Shared widths, the voxel record type and the back-end state type for the
// temporal vector deviation-norm block.
// ----------------------------------------------------------------------------
package tvsn_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_FRAMES  = 64;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_FRAMES);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int QS_W   = SQ_W + $clog2(MAX_FRAMES);
    localparam int PROD_W = CNT_W + QS_W;
    localparam int T_W    = PROD_W + 2;
    localparam int M_W    = 2 * CNT_W;
    localparam int FRAC_SHIFT = 10;
    localparam int D_W    = T_W + FRAC_SHIFT + ((T_W + FRAC_SHIFT) % 2);
    localparam int R_W    = D_W / 2;
    localparam int OUT_W  = 20;
    localparam int DIV_STEPS  = D_W;
    localparam int SQRT_STEPS = R_W;
    localparam int STEP_W = $clog2(D_W + 1);

    localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(MAX_FRAMES);
    localparam logic [OUT_W-1:0] OUT_MAX     = '1;

    typedef struct packed {
        logic                    mode;
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] s_x;
        logic signed [SUM_W-1:0] s_y;
        logic signed [SUM_W-1:0] s_z;
        logic [QS_W-1:0]         q_x;
        logic [QS_W-1:0]         q_y;
        logic [QS_W-1:0]         q_z;
    } t_voxel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_back_state;

endpackage

>>> hdl/temporal_vector_stddev_norm.sv
// ----------------------------------------------------------------------------
// temporal_vector_stddev_norm
// Norm of the per-component temporal standard deviations of a voxel velocity.
// ----------------------------------------------------------------------------
// Frames are taken one per cycle while the queue is not full, and the first
// 64 frames of a voxel are summed as they arrive. A frame marked last closes
// the voxel, and its totals enter a two-entry queue. The solver takes each
// voxel in turn: the pop, three multiply and accumulate pairs for the spread
// terms, a 56-step bit-serial division, a 28-step digit-serial square root
// and the load of the output register. A voxel whose divisor is zero skips
// the division and the root. The solver waits to load a new result while the
// last one is still held for m_axis_tready, and the input stalls whenever the
// queue is full. Results appear in voxel order on the master side, with 4
// fraction bits.
module temporal_vector_stddev_norm import tvsn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: sample_x [15:0], sample_y [31:16], sample_z [47:32]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: deviation_norm [19:0], zero fill [23:20]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    logic             r_mode;
    logic             accept, push, full, q_valid, pop;
    t_voxel           push_data, q_data;
    logic [OUT_W-1:0] norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    tvsn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sample_x  (s_axis_tdata[15:0]),
        .i_sample_y  (s_axis_tdata[31:16]),
        .i_sample_z  (s_axis_tdata[47:32]),
        .i_last_frame(s_axis_tlast),
        .i_mode      (r_mode),
        .o_push      (push),
        .o_voxel     (push_data)
    );

    tvsn_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_data),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    tvsn_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_voxel(q_data),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .o_norm (norm),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, norm};

endmodule

>>> hdl/tvsn_front.sv
// ----------------------------------------------------------------------------
// tvsn_front
// Accumulates sums and sums of squares of one voxel's frames and hands the
// totals on at the voxel's last frame.
// ----------------------------------------------------------------------------
module tvsn_front import tvsn_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_x,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_y,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_z,
    input  logic                          i_last_frame,
    input  logic                          i_mode,
    output logic                          o_push,
    output t_voxel                        o_voxel
);

    logic [CNT_W-1:0]        r_n,   n_n;
    logic signed [SUM_W-1:0] r_s_x, n_s_x, r_s_y, n_s_y, r_s_z, n_s_z;
    logic [QS_W-1:0]         r_q_x, n_q_x, r_q_y, n_q_y, r_q_z, n_q_z;
    logic                    take;

    function automatic logic [SQ_W-1:0] sq(input logic signed [SAMPLE_BITS-1:0] v);
        logic signed [2*SAMPLE_BITS-1:0] p;
        p = v * v;
        return p[SQ_W-1:0];
    endfunction

    always_comb begin
        take  = (r_n != FRAME_LIMIT);
        n_n   = r_n;
        n_s_x = r_s_x;
        n_s_y = r_s_y;
        n_s_z = r_s_z;
        n_q_x = r_q_x;
        n_q_y = r_q_y;
        n_q_z = r_q_z;
        if (take) begin
            n_n   = r_n + 1'b1;
            n_s_x = r_s_x + SUM_W'(i_sample_x);
            n_s_y = r_s_y + SUM_W'(i_sample_y);
            n_s_z = r_s_z + SUM_W'(i_sample_z);
            n_q_x = r_q_x + QS_W'(sq(i_sample_x));
            n_q_y = r_q_y + QS_W'(sq(i_sample_y));
            n_q_z = r_q_z + QS_W'(sq(i_sample_z));
        end
    end

    assign o_push  = i_accept && i_last_frame;
    assign o_voxel = '{mode: i_mode, n: n_n, s_x: n_s_x, s_y: n_s_y, s_z: n_s_z,
                       q_x: n_q_x, q_y: n_q_y, q_z: n_q_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_n   <= '0;
            r_s_x <= '0;
            r_s_y <= '0;
            r_s_z <= '0;
            r_q_x <= '0;
            r_q_y <= '0;
            r_q_z <= '0;
        end else if (i_accept) begin
            r_n   <= n_n;
            r_s_x <= n_s_x;
            r_s_y <= n_s_y;
            r_s_z <= n_s_z;
            r_q_x <= n_q_x;
            r_q_y <= n_q_y;
            r_q_z <= n_q_z;
        end
    end

endmodule

>>> hdl/tvsn_queue.sv
// ----------------------------------------------------------------------------
// tvsn_queue
// Two-entry queue of finished voxel totals between accumulator and solver.
// ----------------------------------------------------------------------------
module tvsn_queue import tvsn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_voxel i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_voxel o_data
);

    t_voxel     r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> hdl/tvsn_back.sv
// ----------------------------------------------------------------------------
// tvsn_back
// Solver: forms the summed spread and, unless the divisor is zero, divides it
// bit-serially and takes a digit-by-digit square root, then holds the result.
// ----------------------------------------------------------------------------
module tvsn_back import tvsn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_voxel           i_voxel,
    output logic             o_pop,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_norm,
    input  logic             i_ready
);

    t_back_state r_state, n_state;

    t_voxel           r_vox;
    logic [1:0]       r_comp;
    logic [PROD_W-1:0] r_nq, r_ss;
    logic [T_W-1:0]   r_t;
    logic [M_W-1:0]   r_m;
    logic [D_W-1:0]   r_div;
    logic [M_W:0]     r_rem;
    logic [R_W-1:0]   r_root;
    logic [R_W+1:0]   r_srem;
    logic [STEP_W-1:0] r_step;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out;

    logic signed [SUM_W-1:0] sel_s;
    logic [QS_W-1:0]         sel_q;
    logic [SUM_W-1:0]        abs_s;
    logic [M_W:0]            rem_sh;
    logic [R_W+1:0]          srem_sh, trial;
    logic [R_W:0]            rounded;
    logic                    load_out;

    always_comb begin
        unique case (r_comp)
            2'd0:    begin sel_s = r_vox.s_x; sel_q = r_vox.q_x; end
            2'd1:    begin sel_s = r_vox.s_y; sel_q = r_vox.q_y; end
            default: begin sel_s = r_vox.s_z; sel_q = r_vox.q_z; end
        endcase
        abs_s   = sel_s[SUM_W-1] ? SUM_W'(-sel_s) : SUM_W'(sel_s);
        rem_sh  = {r_rem[M_W-1:0], r_div[D_W-1]};
        srem_sh = {r_srem[R_W-1:0], r_div[D_W-1:D_W-2]};
        trial   = {r_root, 2'b01};
        rounded = {1'b0, r_root} + 1'b1;
    end

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                if (r_comp != 2'd2) begin
                    n_state = ST_MUL;
                end else if (r_m == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:  if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_SQRT;
            ST_SQRT: if (r_step == STEP_W'(SQRT_STEPS - 1)) n_state = ST_DONE;
            ST_DONE: if (load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_pop = (r_state == ST_IDLE) && i_valid;
    end

    assign o_valid = r_out_valid;
    assign o_norm  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_vox  <= i_voxel;
                r_comp <= '0;
                r_t    <= '0;
                r_step <= '0;
                r_rem  <= '0;
                r_srem <= '0;
                r_root <= '0;
                if (i_voxel.mode) begin
                    r_m <= (i_voxel.n > CNT_W'(1))
                        ? M_W'(i_voxel.n * (i_voxel.n - 1'b1)) : '0;
                end else begin
                    r_m <= M_W'(i_voxel.n * i_voxel.n);
                end
            end
            ST_MUL: begin
                r_nq <= PROD_W'(r_vox.n * sel_q);
                r_ss <= PROD_W'(abs_s * abs_s);
            end
            ST_ACC: begin
                // A spread that rounds below zero counts as nothing.
                if (r_nq > r_ss) begin
                    r_t <= r_t + T_W'(r_nq - r_ss);
                end
                r_comp <= r_comp + 1'b1;
                r_div  <= D_W'({r_t + T_W'((r_nq > r_ss) ? (r_nq - r_ss) : '0),
                                FRAC_SHIFT'(0)});
            end
            ST_DIV: begin
                // Restoring division; quotient bits fill the dividend from below.
                if (rem_sh >= {1'b0, r_m}) begin
                    r_rem <= rem_sh - {1'b0, r_m};
                    r_div <= {r_div[D_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_div <= {r_div[D_W-2:0], 1'b0};
                end
                r_step <= (r_step == STEP_W'(DIV_STEPS - 1)) ? '0 : r_step + 1'b1;
            end
            ST_SQRT: begin
                if (srem_sh >= trial) begin
                    r_srem <= srem_sh - trial;
                    r_root <= {r_root[R_W-2:0], 1'b1};
                end else begin
                    r_srem <= srem_sh;
                    r_root <= {r_root[R_W-2:0], 1'b0};
                end
                r_div  <= {r_div[D_W-3:0], 2'b00};
                r_step <= r_step + 1'b1;
            end
            ST_DONE: begin
                if (load_out) begin
                    if (r_m == '0) begin
                        r_out <= '0;
                    end else if (rounded[R_W:1] > R_W'(OUT_MAX)) begin
                        r_out <= OUT_MAX;
                    end else begin
                        r_out <= rounded[OUT_W:1];
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hdl/tvsn_checker.sv
// ----------------------------------------------------------------------------
// tvsn_checker
// Port-level checks on the deviation-norm block, bound to the top level.
// ----------------------------------------------------------------------------
module tvsn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before transfer");

    // The fill bits above the result are always zero when a result is offered.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:20] == 4'b0000))
        else $error("fill bits set");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind temporal_vector_stddev_norm tvsn_checker u_tvsn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
